// File: rtl/cww_pkg.sv
// Shared types and constants for the counter with waiter wakeup.
// Used by cww_front, cww_back and counter_with_waiter_wakeup_top.
package cww_pkg;

  // Table geometry
  localparam int WAITER_SLOTS = 8;
  localparam int SCAN_LIMIT   = 8;
  localparam int SCAN_MAX     = (WAITER_SLOTS < SCAN_LIMIT) ? WAITER_SLOTS : SCAN_LIMIT;
  localparam int SLOT_IW      = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1;

  // Command queue between front and back
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Configuration register
  localparam logic [3:0] SLOTS_RESET = 4'd8;

  // Result kinds
  localparam logic KIND_WAKE  = 1'b0;
  localparam logic KIND_FINAL = 1'b1;

  typedef enum logic [1:0] {
    OP_INC        = 2'd0,
    OP_DEC        = 2'd1,
    OP_ADD_WAITER = 2'd2,
    OP_READ       = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ADD_STORED    = 2'd0,
    ADD_SATISFIED = 2'd1,
    ADD_NO_FREE   = 2'd2
  } add_status_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_MATCH = 2'd1,
    ST_WAKE  = 2'd2
  } state_t;

  // One queued command
  typedef struct packed {
    op_t         op;
    logic        is_update;
    logic [31:0] amount;
    logic [15:0] fiber_id;
    logic [31:0] target_count;
  } item_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } qhead_t;

endpackage

// File: rtl/cww_front.sv
// Front end: takes command transactions, classifies them and queues them.
// Depends on cww_pkg for the item and queue head types.
module cww_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [1:0]     in_opcode,
  input  logic [31:0]    in_amount,
  input  logic [15:0]    in_fiber_id,
  input  logic [31:0]    in_target_count,
  output logic           busy,
  input  logic           pop_i,
  output cww_pkg::qhead_t head_o
);
  import cww_pkg::*;

  item_t             q_mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push;
  logic              pop;
  item_t             new_item;

  // Classify the incoming command
  always_comb begin
    new_item.op           = op_t'(in_opcode);
    new_item.is_update    = (op_t'(in_opcode) == OP_INC) || (op_t'(in_opcode) == OP_DEC);
    new_item.amount       = in_amount;
    new_item.fiber_id     = in_fiber_id;
    new_item.target_count = in_target_count;
  end

  assign busy = (cnt_r == QCNT_W'(QDEPTH));
  assign push = start && !busy;
  assign pop  = pop_i && (cnt_r != '0);

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Hold queued commands
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= new_item;
    end
  end

  assign head_o.valid = (cnt_r != '0);
  assign head_o.item  = q_mem_r[rd_ptr_r];

endmodule

// File: rtl/cww_back.sv
// Back end: executes queued commands on the count and the waiter table
// and drives result transactions. Depends on cww_pkg.
module cww_back (
  input  logic            clk,
  input  logic            rst_n,
  input  cww_pkg::qhead_t head_i,
  output logic            pop_o,
  input  logic [3:0]      slots_in_use_i,
  output logic            out_strobe,
  output logic            out_kind,
  output logic [15:0]     out_woken_fiber,
  output logic [31:0]     out_prior_count,
  output logic [1:0]      out_add_status,
  output logic            out_last
);
  import cww_pkg::*;

  function automatic logic [SLOT_IW-1:0] lowest_idx(input logic [WAITER_SLOTS-1:0] v);
    logic [SLOT_IW-1:0] idx;
    idx = '0;
    for (int i = WAITER_SLOTS - 1; i >= 0; i--) begin
      if (v[i]) idx = SLOT_IW'(i);
    end
    return idx;
  endfunction

  state_t                  state_r, state_nxt;
  logic [31:0]             count_r;
  logic [31:0]             prior_r;
  logic [WAITER_SLOTS-1:0] occ_r;
  logic [WAITER_SLOTS-1:0] match_r;
  logic [15:0]             slot_fiber_r  [WAITER_SLOTS];
  logic [31:0]             slot_target_r [WAITER_SLOTS];

  logic                    out_strobe_r;
  logic                    out_kind_r;
  logic [15:0]             out_fiber_r;
  logic [31:0]             out_prior_r;
  add_status_t             out_status_r;
  logic                    out_last_r;

  logic [WAITER_SLOTS-1:0] scan_mask;
  logic [WAITER_SLOTS-1:0] free_vec;
  logic [WAITER_SLOTS-1:0] eq_vec;
  logic [SLOT_IW-1:0]      free_idx;
  logic [SLOT_IW-1:0]      wake_idx;
  logic                    satisfied;
  logic [31:0]             count_upd;
  add_status_t             add_status;

  logic                    do_update;
  logic                    do_add;
  logic                    do_read;
  logic                    do_match;
  logic                    do_wake;
  logic                    do_final;

  // Slot scan window and parallel compares
  always_comb begin
    for (int i = 0; i < WAITER_SLOTS; i++) begin
      scan_mask[i] = (i < SCAN_MAX) && (7'(i) < 7'(slots_in_use_i));
      eq_vec[i]    = (slot_target_r[i] == count_r);
    end
    free_vec  = scan_mask & ~occ_r;
    free_idx  = lowest_idx(free_vec);
    wake_idx  = lowest_idx(match_r);
    satisfied = (head_i.item.target_count == count_r);
    count_upd = (head_i.item.op == OP_INC) ? count_r + head_i.item.amount
                                           : count_r - head_i.item.amount;
    if (free_vec == '0) begin
      add_status = ADD_NO_FREE;
    end else if (satisfied) begin
      add_status = ADD_SATISFIED;
    end else begin
      add_status = ADD_STORED;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (head_i.valid && head_i.item.is_update) state_nxt = ST_MATCH;
      end
      ST_MATCH: state_nxt = ST_WAKE;
      ST_WAKE: begin
        if (match_r == '0) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control decode
  always_comb begin
    pop_o     = 1'b0;
    do_update = 1'b0;
    do_add    = 1'b0;
    do_read   = 1'b0;
    do_match  = 1'b0;
    do_wake   = 1'b0;
    do_final  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (head_i.valid) begin
          pop_o     = 1'b1;
          do_update = head_i.item.is_update;
          do_add    = (head_i.item.op == OP_ADD_WAITER);
          do_read   = (head_i.item.op == OP_READ);
        end
      end
      ST_MATCH: do_match = 1'b1;
      ST_WAKE: begin
        do_wake  = (match_r != '0);
        do_final = (match_r == '0);
      end
      default: ;
    endcase
  end

  // Control state, count and slot occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      occ_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= do_add || do_read || do_wake || do_final;
      if (do_update) begin
        count_r <= count_upd;
      end
      if (do_add && (add_status == ADD_STORED)) begin
        occ_r[free_idx] <= 1'b1;
      end
      if (do_wake) begin
        occ_r[wake_idx] <= 1'b0;
      end
    end
  end

  // Payload: prior count, match vector, slot contents, result fields
  always_ff @(posedge clk) begin
    if (do_update) begin
      prior_r <= count_r;
    end
    if (do_match) begin
      match_r <= occ_r & scan_mask & eq_vec;
    end else if (do_wake) begin
      match_r[wake_idx] <= 1'b0;
    end
    if (do_add && (add_status == ADD_STORED)) begin
      slot_fiber_r[free_idx]  <= head_i.item.fiber_id;
      slot_target_r[free_idx] <= head_i.item.target_count;
    end
    if (do_wake) begin
      out_kind_r   <= KIND_WAKE;
      out_fiber_r  <= slot_fiber_r[wake_idx];
      out_prior_r  <= '0;
      out_status_r <= ADD_STORED;
      out_last_r   <= 1'b0;
    end else if (do_final) begin
      out_kind_r   <= KIND_FINAL;
      out_fiber_r  <= '0;
      out_prior_r  <= prior_r;
      out_status_r <= ADD_STORED;
      out_last_r   <= 1'b1;
    end else if (do_add || do_read) begin
      out_kind_r   <= KIND_FINAL;
      out_fiber_r  <= '0;
      out_prior_r  <= count_r;
      out_status_r <= do_add ? add_status : ADD_STORED;
      out_last_r   <= 1'b1;
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_kind        = out_kind_r;
  assign out_woken_fiber = out_fiber_r;
  assign out_prior_count = out_prior_r;
  assign out_add_status  = out_status_r;
  assign out_last        = out_last_r;

`ifndef NO_ASSERTIONS
  // Pending wakes only name occupied slots inside the scan window
  a_match_occupied: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WAKE) |-> ((match_r & ~(occ_r & scan_mask)) == '0))
    else $error("wake pending on a free or out-of-window slot");

  // The back end only pops a queued command
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop_o |-> head_i.valid)
    else $error("pop from an empty command queue");

  // Leaving the wake phase always delivers the final reply
  a_final_on_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WAKE && match_r == '0) |=> (out_strobe_r && out_last_r))
    else $error("update finished without a final reply");

  // A wake notice always frees its slot
  a_wake_frees: assert property (@(posedge clk) disable iff (!rst_n)
    do_wake |=> !occ_r[$past(wake_idx)])
    else $error("woken slot still occupied");
`endif

endmodule

// File: rtl/counter_with_waiter_wakeup_top.sv
// Top level of the counter with waiter wakeup: configuration register,
// command front end and execution back end. Depends on cww_pkg, cww_front, cww_back.
//
// Usage:
//   Commands enter on start/in_* and are taken at an edge where start is high
//   and busy is low. busy rises only when the two-entry command queue is full.
//   Each command yields results on out_*, one per cycle, flagged by out_strobe:
//   wake notices (out_kind 0) in slot order, then one final reply (out_last 1).
//   The receiver cannot stall; every strobed result is taken in its cycle.
//   From acceptance to the final reply, add waiter and read are answered
//   straight from the queue head; increment and decrement pass through the
//   count update, registered match of the slots in the scan window, then the wake drain.
//   The back end takes a new command straight after an add waiter or read,
//   but after an increment or decrement only once its final reply is issued.
//   The APB port writes slots_in_use (register 0); write it only while idle.
//   Reset (rst_n low, synchronous) clears the count, frees all slots, empties
//   the queue and sets slots_in_use to 8.
module counter_with_waiter_wakeup_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_amount,
  input  logic [15:0] in_fiber_id,
  input  logic [31:0] in_target_count,
  output logic        out_strobe,
  output logic        out_kind,
  output logic [15:0] out_woken_fiber,
  output logic [31:0] out_prior_count,
  output logic [1:0]  out_add_status,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cww_pkg::*;

  logic [3:0] slots_in_use_r;
  logic       cfg_wr;
  qhead_t     head;
  logic       pop;

  // Register write on the APB access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_in_use_r <= SLOTS_RESET;
    end else if (cfg_wr) begin
      slots_in_use_r <= pwdata[3:0];
    end
  end

  assign prdata = {28'd0, slots_in_use_r};

  cww_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .in_opcode       (in_opcode),
    .in_amount       (in_amount),
    .in_fiber_id     (in_fiber_id),
    .in_target_count (in_target_count),
    .busy            (busy),
    .pop_i           (pop),
    .head_o          (head)
  );

  cww_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_i          (head),
    .pop_o           (pop),
    .slots_in_use_i  (slots_in_use_r),
    .out_strobe      (out_strobe),
    .out_kind        (out_kind),
    .out_woken_fiber (out_woken_fiber),
    .out_prior_count (out_prior_count),
    .out_add_status  (out_add_status),
    .out_last        (out_last)
  );

endmodule
